>>> design/lbsa_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the load-balanced slot allocator.
package lbsa_pkg;

    localparam int TICKS    = 8;
    localparam int SLOTS    = 32;
    localparam int TICK_LOG = $clog2(TICKS);
    localparam int SLOG_W   = $clog2(TICK_LOG + 1);
    localparam int CNT_W    = TICK_LOG + 1;

    localparam int ID_W     = 6;
    localparam int PLOG_W   = 4;
    localparam int LEN_W    = 16;
    localparam int LOAD_W   = 24;
    localparam int FILL_W   = $clog2(SLOTS);
    localparam int DLOG_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COST_W   = 38;

    localparam int ONE_TICK   = 65536;
    localparam int DIV_LOG_LIMIT = 8;
    localparam int PLOG_LIMIT = TICK_LOG + DIV_LOG_LIMIT;

    typedef logic signed [COST_W-1:0] cost_t;

    localparam cost_t COST_FULL   = cost_t'(64'sd99999 * 64'sd65536);
    localparam cost_t COST_PREFER = cost_t'(-64'sd65536);

    localparam logic [STATUS_W-1:0] STATUS_PLACED     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PERIOD_BIG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [LOAD_W-1:0] load;
    } bucket_t;

    typedef struct packed {
        logic [DLOG_W-1:0] dlog;
        logic [ID_W-1:0]   id;
    } slot_rec_t;

endpackage

>>> design/load_balanced_slot_allocator_top.sv
`timescale 1ns / 1ps
// Load-balanced slot allocator: bucket memory, start scan and slot write-back.
// A valid task scans all buckets through the read and cost pipeline, picks a start in
// the decide state, then reads and writes back one bucket for each placed slot.
// A too-long period is answered from the error state; so is a full target bucket.
// One task at a time; the bucket memory read-modify-write loop sets the rate.
// Reset clears control and per-bucket valid flags (unwritten buckets read as zero
// load and fill); slot records stay undefined until written. No clearing pass.
module load_balanced_slot_allocator_top
    import lbsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                task_valid,
    output logic                task_ready,
    input  logic [ID_W-1:0]     task_id,
    input  logic [PLOG_W-1:0]   period_log2,
    input  logic [LEN_W-1:0]    task_length,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [STATUS_W-1:0] status,
    output logic [TICK_LOG-1:0] tick_index,
    output logic [FILL_W-1:0]   slot_index,
    output logic [DLOG_W-1:0]   divider_log2,
    output logic                last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_WRD    = 3'd3;
    localparam logic [2:0] S_WWR    = 3'd4;
    localparam logic [2:0] S_ERR    = 3'd5;

    logic [2:0] state_reg, state_next;

    // task registers
    logic [ID_W-1:0]     id_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [DLOG_W-1:0]   dlog_reg;
    logic [SLOG_W-1:0]   slog_reg;
    logic                prefer_reg;

    // memories
    bucket_t   bucket_mem [TICKS];
    slot_rec_t slot_mem [TICKS*SLOTS];
    bucket_t   mem_rdata_reg;
    logic      mem_re;
    logic [TICK_LOG-1:0] mem_raddr;
    logic      mem_we;
    bucket_t   mem_wdata;
    logic [TICKS-1:0] bucket_vld_reg;
    logic      rd_vld_reg;
    bucket_t   rd_bucket;

    // scan
    logic [CNT_W-1:0]    n_reg;
    logic [SLOG_W-1:0]   clog;
    logic [TICK_LOG-1:0] kmask;
    logic [TICK_LOG-1:0] scan_t, scan_k, scan_idx;
    logic                scan_issue;

    logic                d_vld_reg, d_first_reg, d_last_reg, d_end_reg;
    logic [TICK_LOG-1:0] d_t_reg, d_idx_reg;
    logic [LOAD_W:0]     d_sum;
    logic                d_over;
    cost_t               d_cost;

    logic                c_vld_reg, c_first_reg, c_last_reg, c_end_reg, c_full_reg;
    logic [TICK_LOG-1:0] c_t_reg, c_idx_reg;
    cost_t               c_cost_reg;

    cost_t               acc_reg, acc_sum;
    logic                tff_reg, tff_now;
    logic [TICK_LOG-1:0] tffidx_reg, tffidx_now;
    logic                lt;

    cost_t               best_cost_reg;
    logic [TICK_LOG-1:0] best_reg, best_ffidx_reg;
    logic                best_ff_reg;

    // write pass
    logic [TICK_LOG-1:0] wk_reg;
    logic [TICK_LOG-1:0] wb;
    logic                wlast;
    logic [LEN_W-1:0]    add_load;
    logic [LOAD_W:0]     new_load;
    logic                out_free;
    logic                out_load_ok;

    logic [STATUS_W-1:0] pend_status_reg;
    logic [TICK_LOG-1:0] pend_tick_reg;

    // outputs
    logic                result_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [TICK_LOG-1:0] tick_reg;
    logic [FILL_W-1:0]   slot_reg;
    logic [DLOG_W-1:0]   dlog_out_reg;
    logic                last_reg;

    logic accept;

    assign task_ready   = (state_reg == S_IDLE);
    assign accept       = task_valid && task_ready;
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign tick_index   = tick_reg;
    assign slot_index   = slot_reg;
    assign divider_log2 = dlog_out_reg;
    assign last         = last_reg;

    assign out_free = !result_valid_reg || result_ready;

    // scan address generation: idx = t + starts*k
    always_comb
    begin
        clog       = SLOG_W'(TICK_LOG) - slog_reg;
        kmask      = TICK_LOG'((1 << clog) - 1);
        scan_t     = n_reg[TICK_LOG-1:0] >> clog;
        scan_k     = n_reg[TICK_LOG-1:0] & kmask;
        scan_idx   = scan_t | (scan_k << slog_reg);
        scan_issue = (state_reg == S_SCAN) && (n_reg < CNT_W'(TICKS));
    end

    // write-pass target bucket
    always_comb
    begin
        wb    = best_reg + (wk_reg << slog_reg);
        wlast = (wk_reg == kmask);
    end

    assign rd_bucket = rd_vld_reg ? mem_rdata_reg : '0;

    always_comb
    begin
        mem_re    = scan_issue || (state_reg == S_WRD);
        mem_raddr = scan_issue ? scan_idx : wb;
    end

    // cost of one bucket
    always_comb
    begin
        d_sum  = {1'b0, rd_bucket.load} + (LOAD_W+1)'(len_reg);
        d_over = d_sum >= (LOAD_W+1)'(ONE_TICK);
        if (d_over)
            d_cost = COST_FULL;
        else if (prefer_reg && (d_t_reg == TICK_LOG'(TICKS - 1)))
            d_cost = COST_PREFER;
        else
            d_cost = cost_t'({{(COST_W-LOAD_W){1'b0}}, rd_bucket.load});
    end

    // accumulate per start, track first full target
    always_comb
    begin
        acc_sum = (c_first_reg ? cost_t'(0) : acc_reg) + c_cost_reg;
        if (c_first_reg)
        begin
            tff_now    = c_full_reg;
            tffidx_now = c_idx_reg;
        end
        else if (tff_reg)
        begin
            tff_now    = 1'b1;
            tffidx_now = tffidx_reg;
        end
        else
        begin
            tff_now    = c_full_reg;
            tffidx_now = c_idx_reg;
        end
        lt = acc_sum < best_cost_reg;
    end

    // slot write-back
    always_comb
    begin
        add_load       = len_reg >> dlog_reg;
        new_load       = {1'b0, rd_bucket.load} + (LOAD_W+1)'(add_load);
        out_load_ok    = (state_reg == S_WWR) && out_free;
        mem_we         = out_load_ok;
        mem_wdata.fill = rd_bucket.fill + FILL_W'(1);
        mem_wdata.load = new_load[LOAD_W] ? {LOAD_W{1'b1}} : new_load[LOAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bucket_mem[wb] <= mem_wdata;
            slot_mem[{wb, rd_bucket.fill}] <= '{dlog: dlog_reg, id: id_reg};
        end
        if (mem_re)
            mem_rdata_reg <= bucket_mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (period_log2 >= PLOG_W'(PLOG_LIMIT)) ? S_ERR : S_SCAN;
            end
            S_SCAN:
            begin
                if (c_vld_reg && c_end_reg)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = best_ff_reg ? S_ERR : S_WRD;
            end
            S_WRD:
            begin
                state_next = S_WWR;
            end
            S_WWR:
            begin
                if (out_free)
                    state_next = wlast ? S_IDLE : S_WRD;
            end
            S_ERR:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bucket_vld_reg   <= '0;
            d_vld_reg        <= 1'b0;
            c_vld_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            d_vld_reg <= scan_issue;
            c_vld_reg <= d_vld_reg;
            if (mem_we)
                bucket_vld_reg[wb] <= 1'b1;
            if (out_load_ok || ((state_reg == S_ERR) && out_free))
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg        <= task_id;
            len_reg       <= task_length;
            n_reg         <= '0;
            best_cost_reg <= COST_FULL;
            best_reg      <= '0;
            best_ff_reg   <= 1'b0;
            if (period_log2 > PLOG_W'(TICK_LOG))
            begin
                prefer_reg <= 1'b1;
                slog_reg   <= SLOG_W'(TICK_LOG);
                dlog_reg   <= DLOG_W'(period_log2 - PLOG_W'(TICK_LOG));
            end
            else
            begin
                prefer_reg <= 1'b0;
                slog_reg   <= SLOG_W'(period_log2);
                dlog_reg   <= '0;
            end
            pend_status_reg <= STATUS_PERIOD_BIG;
            pend_tick_reg   <= '0;
        end

        if (mem_re)
            rd_vld_reg <= bucket_vld_reg[mem_raddr];

        if (scan_issue)
        begin
            n_reg       <= n_reg + CNT_W'(1);
            d_first_reg <= (scan_k == '0);
            d_last_reg  <= (scan_k == kmask);
            d_end_reg   <= (n_reg == CNT_W'(TICKS - 1));
            d_t_reg     <= scan_t;
            d_idx_reg   <= scan_idx;
        end

        if (d_vld_reg)
        begin
            c_cost_reg  <= d_cost;
            c_full_reg  <= (rd_bucket.fill >= FILL_W'(SLOTS - 1));
            c_first_reg <= d_first_reg;
            c_last_reg  <= d_last_reg;
            c_end_reg   <= d_end_reg;
            c_t_reg     <= d_t_reg;
            c_idx_reg   <= d_idx_reg;
        end

        if (c_vld_reg)
        begin
            acc_reg    <= acc_sum;
            tff_reg    <= tff_now;
            tffidx_reg <= tffidx_now;
            if (c_last_reg && (lt || (c_t_reg == '0)))
            begin
                best_reg       <= c_t_reg;
                best_ff_reg    <= tff_now;
                best_ffidx_reg <= tffidx_now;
            end
            if (c_last_reg && lt)
                best_cost_reg <= acc_sum;
        end

        if (state_reg == S_DECIDE)
        begin
            wk_reg          <= '0;
            pend_status_reg <= STATUS_FULL;
            pend_tick_reg   <= best_ffidx_reg;
        end

        if (out_load_ok)
        begin
            wk_reg       <= wk_reg + TICK_LOG'(1);
            status_reg   <= STATUS_PLACED;
            tick_reg     <= wb;
            slot_reg     <= rd_bucket.fill;
            dlog_out_reg <= dlog_reg;
            last_reg     <= wlast;
        end
        else if ((state_reg == S_ERR) && out_free)
        begin
            status_reg   <= pend_status_reg;
            tick_reg     <= pend_tick_reg;
            slot_reg     <= '0;
            dlog_out_reg <= '0;
            last_reg     <= 1'b1;
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the load-balanced slot allocator.
module tb;
    import lbsa_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_TASKS = 470;
    localparam int QUIET_TAIL   = 70;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TICK_LOG-1:0] tick;
        logic [FILL_W-1:0]   slot;
        logic [DLOG_W-1:0]   dlog;
        logic                last;
    } slot_result_t;

    class slot_ledger;
        bit [LOAD_W-1:0] load[TICKS];
        bit [FILL_W-1:0] fill[TICKS];
        slot_result_t    owed[$];
        int              errors;

        function new();
            foreach (load[i])
            begin
                load[i] = '0;
                fill[i] = '0;
            end
            errors = 0;
        endfunction

        function void owe(logic [STATUS_W-1:0] st, int unsigned tk, int unsigned sl,
                          int unsigned dl, bit ls);
            slot_result_t r;
            r.status = st;
            r.tick   = tk[TICK_LOG-1:0];
            r.slot   = sl[FILL_W-1:0];
            r.dlog   = dl[DLOG_W-1:0];
            r.last   = ls;
            owed.push_back(r);
        endfunction

        // Placement of one task: start scan, full-bucket check, slot write-back.
        function void note_task(bit [ID_W-1:0] id, bit [PLOG_W-1:0] plog,
                                bit [LEN_W-1:0] len);
            int unsigned period, divider, dlog, count, starts, idx, b, best, nl;
            bit          prefer;
            longint      total, c, best_cost;
            period    = 1 << plog;
            prefer    = period > TICKS;
            divider   = 1;
            dlog      = 0;
            best      = 0;
            best_cost = longint'(COST_FULL);
            if (prefer)
            begin
                divider = period / TICKS;
                if (divider >= (1 << DIV_LOG_LIMIT))
                begin
                    owe(STATUS_PERIOD_BIG, 0, 0, 0, 1'b1);
                    return;
                end
                dlog  = plog - TICK_LOG;
                count = 1;
            end
            else
                count = TICKS / period;
            starts = TICKS / count;

            for (int t = 0; t < starts; t++)
            begin
                total = 0;
                for (int k = 0; k < count; k++)
                begin
                    idx = t + starts * k;
                    if (idx >= TICKS)
                        continue;
                    if (int'(load[idx]) + int'(len) >= ONE_TICK)
                        c = longint'(COST_FULL);
                    else if (prefer && t == starts - 1)
                        c = longint'(COST_PREFER);
                    else
                        c = longint'(load[idx]);
                    total += c;
                end
                if (total < best_cost)
                begin
                    best_cost = total;
                    best      = t;
                end
            end

            b = best;
            for (int k = 0; k < count; k++)
            begin
                if (fill[b] + 1 >= SLOTS)
                begin
                    owe(STATUS_FULL, b, 0, 0, 1'b1);
                    return;
                end
                b = (b + period) % TICKS;
            end

            b = best;
            for (int k = 0; k < count; k++)
            begin
                owe(STATUS_PLACED, b, fill[b], dlog, k + 1 == count);
                nl      = load[b] + (len >> dlog);
                load[b] = (nl > {LOAD_W{1'b1}}) ? {LOAD_W{1'b1}} : nl[LOAD_W-1:0];
                fill[b] = fill[b] + 1'b1;
                b       = (b + period) % TICKS;
            end
        endfunction

        function void check_result(slot_result_t got);
            slot_result_t exp_r;
            if (owed.size() == 0)
            begin
                $error("result with no task pending: status %0d tick %0d slot %0d",
                       got.status, got.tick, got.slot);
                errors++;
                return;
            end
            exp_r = owed.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.tick !== exp_r.tick)
            begin
                $error("tick_index: expected %0d, got %0d", exp_r.tick, got.tick);
                errors++;
            end
            if (got.slot !== exp_r.slot)
            begin
                $error("slot_index: expected %0d, got %0d", exp_r.slot, got.slot);
                errors++;
            end
            if (got.dlog !== exp_r.dlog)
            begin
                $error("divider_log2: expected %0d, got %0d", exp_r.dlog, got.dlog);
                errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                task_valid;
    logic                task_ready;
    logic [ID_W-1:0]     task_id;
    logic [PLOG_W-1:0]   period_log2;
    logic [LEN_W-1:0]    task_length;
    logic                result_valid;
    logic                result_ready;
    logic [STATUS_W-1:0] status;
    logic [TICK_LOG-1:0] tick_index;
    logic [FILL_W-1:0]   slot_index;
    logic [DLOG_W-1:0]   divider_log2;
    logic                last;

    slot_ledger ledger = new();
    bit         idle_on = 1'b1;
    int         stall_cycles = 0;

    load_balanced_slot_allocator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_ready   (task_ready),
        .task_id      (task_id),
        .period_log2  (period_log2),
        .task_length  (task_length),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .tick_index   (tick_index),
        .slot_index   (slot_index),
        .divider_log2 (divider_log2),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && task_valid && task_ready)
            ledger.note_task(task_id, period_log2, task_length);
        if (rst_n && result_valid && result_ready)
            ledger.check_result({status, tick_index, slot_index, divider_log2, last});
        if ((task_valid && task_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $error("no transaction for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        result_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic send_task(input int id, input int plog, input int len);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            task_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        task_valid  <= 1'b1;
        task_id     <= id[ID_W-1:0];
        period_log2 <= plog[PLOG_W-1:0];
        task_length <= len[LEN_W-1:0];
        do
            @(posedge clk);
        while (!task_ready);
    endtask

    task automatic send_random_task();
        int id, plog, len, pick;
        id   = $urandom_range(0, 63);
        pick = $urandom_range(0, 99);
        if (pick < 20)
            plog = $urandom_range(0, 2);
        else if (pick < 85)
            plog = $urandom_range(3, 10);
        else
            plog = $urandom_range(11, 15);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 0;
        else if (pick < 14)
            len = 65535;
        else if (pick < 30)
            len = $urandom_range(0, 65535);
        else
            len = $urandom_range(0, 2047);
        send_task(id, plog, len);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        task_valid  = 1'b0;
        task_id     = '0;
        period_log2 = '0;
        task_length = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring: long period lands on the last start
        send_task(0, 4, 0);
        send_task(63, 4, 65535);
        // last start now overflows, earliest least-loaded start wins
        send_task(1, 10, 65535);
        // single candidate start 0 places a slot in every bucket
        send_task(2, 0, 0);
        send_task(3, 1, 1);
        send_task(4, 2, 2);
        send_task(5, 3, 3);
        send_task(6, 5, 65535);
        send_task(7, 6, 40000);
        send_task(8, 7, 1234);
        send_task(9, 8, 65535);
        send_task(10, 9, 777);
        send_task(62, 10, 0);
        // divider of 256 and above
        send_task(11, 11, 1);
        send_task(12, 12, 0);
        send_task(13, 13, 65535);
        send_task(14, 14, 7);
        send_task(63, 15, 65535);

        for (int i = 0; i < RANDOM_TASKS; i++)
        begin
            idle_on = (i < RANDOM_TASKS - QUIET_TAIL);
            send_random_task();
        end
        task_valid <= 1'b0;

        while (ledger.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.errors == 0 && ledger.owed.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/lbsa_pkg.sv
design/load_balanced_slot_allocator_top.sv
dv/tb.sv
